// ===== hdl/btbp_pkg.sv =====
// Shared types, constants and helper functions of the two-level branch predictor.
// No dependencies; every other file of the block refers to it by scoped names.
package btbp_pkg;

   // Table geometry
   localparam int BTB_ENTRIES = 32;                  // power of two: index is pc bits
   localparam int IDX_W       = $clog2(BTB_ENTRIES);
   localparam int MAX_HISTORY = 8;
   localparam int HIST_W      = MAX_HISTORY;
   localparam int ROW_CNT     = 1 << MAX_HISTORY;
   localparam int CNT_W       = 2;
   localparam int ROW_W       = ROW_CNT * CNT_W;
   localparam int TAG_W       = 30;
   localparam int ADDR_W      = 32;
   localparam int PC_STEP     = 4;
   localparam int GSHARE_LSB  = 16;
   localparam int LSHARE_LSB  = 2;

   // Saturating counter codes
   localparam logic [CNT_W-1:0] CNT_STRONG_NT = 2'd0;
   localparam logic [CNT_W-1:0] CNT_WEAK_NT   = 2'd1;
   localparam logic [CNT_W-1:0] CNT_WEAK_T    = 2'd2;
   localparam logic [CNT_W-1:0] CNT_STRONG_T  = 2'd3;

   // Operation codes
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   // Index folding modes
   localparam logic [1:0] SHARE_HISTORY = 2'd0;
   localparam logic [1:0] SHARE_LOW_PC  = 2'd1;
   localparam logic [1:0] SHARE_HIGH_PC = 2'd2;

   // Configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_HISTORY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_TABLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_MODE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_BITS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_BITS       = 3'd4;

   localparam logic [3:0] HISTORY_BITS_RESET = 4'd8;
   localparam logic [4:0] TAG_BITS_RESET     = 5'd30;

   typedef struct packed {
      logic       hist_shared;
      logic       global_table;
      logic [1:0] share_mode;
      logic [3:0] history_bits;
      logic [4:0] tag_bits;
   } cfg_type;

   // One BTB entry as stored in the entry memory
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [ADDR_W-1:0] target;
      logic [HIST_W-1:0] hist;
   } entry_type;

   // Result of the direction unit
   typedef struct packed {
      logic              pred;
      logic [HIST_W-1:0] new_hist;
      logic [ROW_W-1:0]  new_row;
   } dir_type;

   // Mask of the active history bits; length clamped to 1..MAX_HISTORY
   function automatic logic [HIST_W-1:0] hist_mask(input logic [3:0] history_bits);
      logic [3:0] len;
      len = history_bits;
      if (len < 4'd1) len = 4'd1;
      if (len > 4'(MAX_HISTORY)) len = 4'(MAX_HISTORY);
      return ~({HIST_W{1'b1}} << len);
   endfunction

   // Tag: low bits of pc>>2, length clamped to TAG_W
   function automatic logic [TAG_W-1:0] tag_of(input logic [4:0] tag_bits,
                                                input logic [ADDR_W-1:0] pc);
      logic [4:0]       len;
      logic [TAG_W-1:0] mask;
      len  = (tag_bits > 5'(TAG_W)) ? 5'(TAG_W) : tag_bits;
      mask = ~({TAG_W{1'b1}} << len);
      return pc[ADDR_W-1:2] & mask;
   endfunction

   // Counter index inside a row
   function automatic logic [HIST_W-1:0] cnt_index(input logic [1:0]        share_mode,
                                                   input logic [HIST_W-1:0] hist,
                                                   input logic [ADDR_W-1:0] pc,
                                                   input logic [HIST_W-1:0] mask);
      logic [HIST_W-1:0] idx;
      unique case (share_mode)
         SHARE_HISTORY: idx = hist;
         SHARE_LOW_PC:  idx = hist ^ pc[LSHARE_LSB +: HIST_W];
         SHARE_HIGH_PC: idx = hist ^ pc[GSHARE_LSB +: HIST_W];
         default:       idx = '0;
      endcase
      return idx & mask;
   endfunction

endpackage

// ===== hdl/btbp_req_if.sv =====
// Request channel of the branch predictor: valid/ready plus one lookup or update.
// Uses btbp_pkg for field widths.
interface btbp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [btbp_pkg::ADDR_W-1:0]    pc;
   logic [btbp_pkg::ADDR_W-1:0]    actual_target;
   logic                           actual_taken;
   logic [btbp_pkg::ADDR_W-1:0]    earlier_prediction;

   modport source (output valid, opcode, pc, actual_target, actual_taken,
                   earlier_prediction, input ready);
   modport sink   (input valid, opcode, pc, actual_target, actual_taken,
                   earlier_prediction, output ready);
endinterface

// Response channel of the branch predictor: valid/ready plus one result.
// Uses btbp_pkg for field widths.
interface btbp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           predict_taken;
   logic [btbp_pkg::ADDR_W-1:0]    predicted_target;
   logic                           mispredicted;
   logic [31:0]                    branch_count;
   logic [31:0]                    flush_count;

   modport source (output valid, predict_taken, predicted_target, mispredicted,
                   branch_count, flush_count, input ready);
   modport sink   (input valid, predict_taken, predicted_target, mispredicted,
                   branch_count, flush_count, output ready);
endinterface

// ===== hdl/btbp_dir_unit.sv =====
// Direction unit: counter selection, prediction, row reset on allocation,
// counter step and history shift. Pure combinational; uses btbp_pkg.
module btbp_dir_unit (
   input  btbp_pkg::cfg_type                 cfg,
   input  logic [btbp_pkg::ADDR_W-1:0]       pc,
   input  logic                              hit,
   input  logic                              taken,
   input  logic [btbp_pkg::HIST_W-1:0]       ent_hist,
   input  logic [btbp_pkg::HIST_W-1:0]       shared_hist,
   input  logic [btbp_pkg::ROW_W-1:0]        local_row,
   input  logic [btbp_pkg::ROW_W-1:0]        shared_row,
   output btbp_pkg::dir_type                 dir_o
);

   logic [btbp_pkg::HIST_W-1:0] mask;
   logic [btbp_pkg::HIST_W-1:0] hist_pre;
   logic [btbp_pkg::HIST_W-1:0] hist_upd;
   logic [btbp_pkg::HIST_W-1:0] idx_pre;
   logic [btbp_pkg::HIST_W-1:0] idx_upd;
   logic [btbp_pkg::ROW_W-1:0]  row_pre;
   logic [btbp_pkg::ROW_W-1:0]  row_clr;
   logic [btbp_pkg::ROW_W-1:0]  row_upd;
   logic [btbp_pkg::CNT_W-1:0]  ctr_pre;
   logic [btbp_pkg::CNT_W-1:0]  ctr_upd;
   logic [btbp_pkg::CNT_W-1:0]  ctr_new;

   assign mask     = btbp_pkg::hist_mask(cfg.history_bits);
   assign hist_pre = cfg.hist_shared ? shared_hist : ent_hist;
   assign row_pre  = cfg.global_table ? shared_row : local_row;
   assign idx_pre  = btbp_pkg::cnt_index(cfg.share_mode, hist_pre, pc, mask);
   assign ctr_pre  = row_pre[{idx_pre, 1'b0} +: btbp_pkg::CNT_W];

   // Allocation wipes the local history and the active part of the local row
   assign hist_upd = cfg.hist_shared ? shared_hist : (hit ? ent_hist : '0);

   always_comb begin
      for (int i = 0; i < btbp_pkg::ROW_CNT; i++) begin
         if ((btbp_pkg::HIST_W'(i) & ~mask) == '0) begin
            row_clr[i*btbp_pkg::CNT_W +: btbp_pkg::CNT_W] = btbp_pkg::CNT_WEAK_NT;
         end else begin
            row_clr[i*btbp_pkg::CNT_W +: btbp_pkg::CNT_W] =
               local_row[i*btbp_pkg::CNT_W +: btbp_pkg::CNT_W];
         end
      end
   end

   assign row_upd = cfg.global_table ? shared_row : (hit ? local_row : row_clr);
   assign idx_upd = btbp_pkg::cnt_index(cfg.share_mode, hist_upd, pc, mask);
   assign ctr_upd = row_upd[{idx_upd, 1'b0} +: btbp_pkg::CNT_W];

   always_comb begin
      if (taken) begin
         ctr_new = (ctr_upd == btbp_pkg::CNT_STRONG_T) ? ctr_upd : ctr_upd + 2'd1;
      end else begin
         ctr_new = (ctr_upd == btbp_pkg::CNT_STRONG_NT) ? ctr_upd : ctr_upd - 2'd1;
      end
   end

   always_comb begin
      dir_o.pred     = hit && (ctr_pre >= btbp_pkg::CNT_WEAK_T);
      dir_o.new_hist = (btbp_pkg::HIST_W'(hist_upd << 1) | btbp_pkg::HIST_W'(taken)) & mask;
      dir_o.new_row  = row_upd;
      dir_o.new_row[{idx_upd, 1'b0} +: btbp_pkg::CNT_W] = ctr_new;
   end

endmodule

// ===== hdl/btb_two_level_branch_predictor.sv =====
// Top level of the two-level branch predictor with branch target buffer.
// Depends on btbp_pkg, btbp_req_if / btbp_rsp_if and btbp_dir_unit.
//
//   channel | direction | handshake             | payload
//   req     | in        | req.valid / req.ready | opcode, pc, actual_target, actual_taken,
//           |           |                       | earlier_prediction
//   rsp     | out       | rsp.valid / rsp.ready | predict_taken, predicted_target,
//           |           |                       | mispredicted, branch_count, flush_count
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// One transaction per cycle unless rsp stalls; the result is registered. The entry and
// counter-row memories are read when a transaction is accepted (write-first, so
// the update leaving the compute stage is forwarded) and written as it leaves.
// Synchronous reset clears the valid bits, shared state and counters; no sweep.
// A stalled rsp holds the output register; req.ready drops only when the
// compute stage and the output register are both full and rsp.ready is low.
module btb_two_level_branch_predictor (
   input  logic                              clock,
   input  logic                              reset,
   btbp_req_if.sink                          req,
   btbp_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [btbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [btbp_pkg::CSR_W-1:0]        csr_wdata
);

   localparam logic [btbp_pkg::ROW_W-1:0] ROW_RESET =
      {btbp_pkg::ROW_CNT{btbp_pkg::CNT_WEAK_NT}};

   // Configuration
   btbp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hist_shared    <= 1'b0;
         cfg_ff.global_table   <= 1'b0;
         cfg_ff.share_mode     <= btbp_pkg::SHARE_HISTORY;
         cfg_ff.history_bits   <= btbp_pkg::HISTORY_BITS_RESET;
         cfg_ff.tag_bits       <= btbp_pkg::TAG_BITS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            btbp_pkg::CSR_GLOBAL_HISTORY: cfg_ff.hist_shared    <= csr_wdata[0];
            btbp_pkg::CSR_GLOBAL_TABLE:   cfg_ff.global_table   <= csr_wdata[0];
            btbp_pkg::CSR_SHARE_MODE:     cfg_ff.share_mode     <= csr_wdata[1:0];
            btbp_pkg::CSR_HISTORY_BITS:   cfg_ff.history_bits   <= csr_wdata[3:0];
            btbp_pkg::CSR_TAG_BITS:       cfg_ff.tag_bits       <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Compute stage
   logic                            s1_valid_ff;
   logic                            s1_op_ff;
   logic [btbp_pkg::ADDR_W-1:0]     s1_pc_ff;
   logic [btbp_pkg::ADDR_W-1:0]     s1_target_ff;
   logic                            s1_taken_ff;
   logic [btbp_pkg::ADDR_W-1:0]     s1_earlier_ff;
   btbp_pkg::entry_type             ent_rd_ff;
   logic [btbp_pkg::ROW_W-1:0]      row_rd_ff;

   // Output register
   logic                            out_valid_ff;
   logic                            out_upd_ff;
   logic                            out_pred_ff;
   logic [btbp_pkg::ADDR_W-1:0]     out_target_ff;
   logic                            out_mis_ff;
   logic [31:0]                     out_branches_ff;
   logic [31:0]                     out_flushes_ff;

   // Architectural state in flops
   logic [btbp_pkg::BTB_ENTRIES-1:0] entry_valid_ff;
   logic [btbp_pkg::BTB_ENTRIES-1:0] row_valid_ff;
   logic [btbp_pkg::HIST_W-1:0]      shared_hist_ff;
   logic [btbp_pkg::ROW_W-1:0]       shared_row_ff;
   logic [31:0]                      branches_ff;
   logic [31:0]                      flushes_ff;
   logic [31:0]                      branches_in;
   logic [31:0]                      flushes_in;

   // Memories
   btbp_pkg::entry_type             ent_mem [btbp_pkg::BTB_ENTRIES];
   logic [btbp_pkg::ROW_W-1:0]      row_mem [btbp_pkg::BTB_ENTRIES];

   logic                            accept;
   logic                            s1_adv;
   logic                            upd_we;
   logic                            row_we;
   logic [btbp_pkg::IDX_W-1:0]      req_idx;
   logic [btbp_pkg::IDX_W-1:0]      s1_idx;
   logic                            hit;
   logic [btbp_pkg::HIST_W-1:0]     ent_hist;
   logic [btbp_pkg::ROW_W-1:0]      local_row;
   logic [btbp_pkg::ADDR_W-1:0]     seq_pc;
   logic [btbp_pkg::ADDR_W-1:0]     pred_target;
   logic                            mis;
   btbp_pkg::entry_type             ent_wr;
   btbp_pkg::dir_type               dir;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;
   assign req_idx   = req.pc[2 +: btbp_pkg::IDX_W];
   assign s1_idx    = s1_pc_ff[2 +: btbp_pkg::IDX_W];
   assign upd_we    = s1_adv && (s1_op_ff == btbp_pkg::OP_UPDATE);
   assign row_we    = upd_we && !cfg_ff.global_table;

   // Never-written entries and rows read as their reset contents
   assign hit = entry_valid_ff[s1_idx] &&
                (ent_rd_ff.tag == btbp_pkg::tag_of(cfg_ff.tag_bits, s1_pc_ff));
   assign ent_hist  = entry_valid_ff[s1_idx] ? ent_rd_ff.hist : '0;
   assign local_row = row_valid_ff[s1_idx] ? row_rd_ff : ROW_RESET;

   btbp_dir_unit u_dir (
      .cfg         (cfg_ff),
      .pc          (s1_pc_ff),
      .hit         (hit),
      .taken       (s1_taken_ff),
      .ent_hist    (ent_hist),
      .shared_hist (shared_hist_ff),
      .local_row   (local_row),
      .shared_row  (shared_row_ff),
      .dir_o       (dir)
   );

   assign seq_pc      = s1_pc_ff + btbp_pkg::ADDR_W'(btbp_pkg::PC_STEP);
   assign pred_target = dir.pred ? ent_rd_ff.target : seq_pc;

   always_comb begin
      priority if (s1_op_ff != btbp_pkg::OP_UPDATE) begin
         mis = 1'b0;
      end else if (dir.pred != s1_taken_ff) begin
         mis = 1'b1;
      end else if (s1_taken_ff) begin
         mis = (s1_target_ff != s1_earlier_ff);
      end else begin
         mis = (seq_pc != s1_earlier_ff);
      end
   end

   assign branches_in = (s1_op_ff == btbp_pkg::OP_UPDATE) ? branches_ff + 32'd1 : branches_ff;
   assign flushes_in  = mis ? flushes_ff + 32'd1 : flushes_ff;

   always_comb begin
      ent_wr.tag    = btbp_pkg::tag_of(cfg_ff.tag_bits, s1_pc_ff);
      ent_wr.target = s1_target_ff;
      // in shared-history mode the entry's own history is left as it was
      ent_wr.hist   = cfg_ff.hist_shared ? ent_hist : dir.new_hist;
   end

   // Memories: write on update leaving the stage, read on accept (write-first)
   always_ff @(posedge clock) begin
      if (upd_we) begin
         ent_mem[s1_idx] <= ent_wr;
      end
      if (accept) begin
         ent_rd_ff <= (upd_we && (s1_idx == req_idx)) ? ent_wr : ent_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[s1_idx] <= dir.new_row;
      end
      if (accept) begin
         row_rd_ff <= (row_we && (s1_idx == req_idx)) ? dir.new_row : row_mem[req_idx];
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req.opcode;
         s1_pc_ff      <= req.pc;
         s1_target_ff  <= req.actual_target;
         s1_taken_ff   <= req.actual_taken;
         s1_earlier_ff <= req.earlier_prediction;
      end
      if (s1_adv) begin
         out_upd_ff      <= (s1_op_ff == btbp_pkg::OP_UPDATE);
         out_pred_ff     <= dir.pred;
         out_target_ff   <= pred_target;
         out_mis_ff      <= mis;
         out_branches_ff <= branches_in;
         out_flushes_ff  <= flushes_in;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         row_valid_ff   <= '0;
         shared_hist_ff <= '0;
         shared_row_ff  <= ROW_RESET;
         branches_ff    <= '0;
         flushes_ff     <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (upd_we) begin
            entry_valid_ff[s1_idx] <= 1'b1;
            branches_ff            <= branches_in;
            flushes_ff             <= flushes_in;
            if (cfg_ff.hist_shared) begin
               shared_hist_ff <= dir.new_hist;
            end
            if (cfg_ff.global_table) begin
               shared_row_ff <= dir.new_row;
            end
         end
         if (row_we) begin
            row_valid_ff[s1_idx] <= 1'b1;
         end
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.predict_taken    = out_pred_ff;
   assign rsp.predicted_target = out_target_ff;
   assign rsp.mispredicted     = out_mis_ff;
   assign rsp.branch_count     = out_branches_ff;
   assign rsp.flush_count      = out_flushes_ff;

   // Assertions
   a_predict_no_mis: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !out_upd_ff) |-> !rsp.mispredicted)
      else $error("predict result flagged as mispredicted");

   a_branch_step: assert property (@(posedge clock) disable iff (reset)
      upd_we |=> (branches_ff == $past(branches_ff) + 32'd1))
      else $error("branch count did not advance on update");

   a_flush_step: assert property (@(posedge clock) disable iff (reset)
      (upd_we && mis) |=> (flushes_ff == $past(flushes_ff) + 32'd1))
      else $error("flush count did not advance on mispredict");

   a_alloc_valid: assert property (@(posedge clock) disable iff (reset)
      upd_we |=> entry_valid_ff[$past(s1_idx)])
      else $error("updated entry not marked valid");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("request stalled with empty compute stage");

endmodule

// ===== tb/btb_two_level_branch_predictor_tb.sv =====
// Self-checking testbench of btb_two_level_branch_predictor: directed corner cases, then
// random lookup/update traffic checked against a behavioral predictor in this file.
// Depends on btbp_pkg and the btbp_req_if / btbp_rsp_if interfaces of the RTL.
module btb_two_level_branch_predictor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                        opcode;
      logic [btbp_pkg::ADDR_W-1:0] pc;
      logic [btbp_pkg::ADDR_W-1:0] actual_target;
      logic                        actual_taken;
      logic [btbp_pkg::ADDR_W-1:0] earlier_prediction;
   } branch_op_type;

   typedef struct {
      logic                        predict_taken;
      logic [btbp_pkg::ADDR_W-1:0] predicted_target;
      logic                        mispredicted;
      logic [31:0]                 branch_count;
      logic [31:0]                 flush_count;
   } branch_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [btbp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [btbp_pkg::CSR_W-1:0]     csr_wdata;

   btbp_req_if req_bus ();
   btbp_rsp_if rsp_bus ();

   btb_two_level_branch_predictor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the block state
   btbp_pkg::cfg_type           model_cfg;
   logic                        entry_valid  [btbp_pkg::BTB_ENTRIES];
   logic [btbp_pkg::TAG_W-1:0]  entry_tag    [btbp_pkg::BTB_ENTRIES];
   logic [btbp_pkg::ADDR_W-1:0] entry_target [btbp_pkg::BTB_ENTRIES];
   logic [btbp_pkg::HIST_W-1:0] entry_hist   [btbp_pkg::BTB_ENTRIES];
   logic [btbp_pkg::HIST_W-1:0] shared_hist;
   logic [btbp_pkg::CNT_W-1:0]  row_cnt      [btbp_pkg::BTB_ENTRIES][btbp_pkg::ROW_CNT];
   logic [btbp_pkg::CNT_W-1:0]  shared_cnt   [btbp_pkg::ROW_CNT];
   logic [31:0]                 branches_seen;
   logic [31:0]                 flushes_seen;

   branch_result_type pending_results [$];
   branch_result_type expected_rsp;
   int                mismatch_count = 0;
   bit                steady = 0;

   // Branch working set for the random traffic
   logic [btbp_pkg::ADDR_W-1:0] hot_pc     [16];
   logic [btbp_pkg::ADDR_W-1:0] hot_target [16];
   int                          hot_bias   [16];
   int                          hot_step   [16];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= 22);
   end

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $display("%0t %s expected %h actual %h", $time, name, exp, act);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected transaction expected none actual %h", $time,
                     rsp_bus.predicted_target);
            mismatch_count++;
         end else begin
            expected_rsp = pending_results.pop_front();
            check_field("predict_taken", 32'(expected_rsp.predict_taken),
                        32'(rsp_bus.predict_taken));
            check_field("predicted_target", expected_rsp.predicted_target,
                        rsp_bus.predicted_target);
            check_field("mispredicted", 32'(expected_rsp.mispredicted),
                        32'(rsp_bus.mispredicted));
            check_field("branch_count", expected_rsp.branch_count, rsp_bus.branch_count);
            check_field("flush_count", expected_rsp.flush_count, rsp_bus.flush_count);
         end
      end
   end

   task automatic reset_model();
      model_cfg = '{hist_shared: 1'b0, global_table: 1'b0,
                    share_mode: btbp_pkg::SHARE_HISTORY,
                    history_bits: btbp_pkg::HISTORY_BITS_RESET,
                    tag_bits: btbp_pkg::TAG_BITS_RESET};
      for (int e = 0; e < btbp_pkg::BTB_ENTRIES; e++) begin
         entry_valid[e]  = 1'b0;
         entry_tag[e]    = '0;
         entry_target[e] = '0;
         entry_hist[e]   = '0;
         for (int i = 0; i < btbp_pkg::ROW_CNT; i++) row_cnt[e][i] = btbp_pkg::CNT_WEAK_NT;
      end
      for (int i = 0; i < btbp_pkg::ROW_CNT; i++) shared_cnt[i] = btbp_pkg::CNT_WEAK_NT;
      shared_hist   = '0;
      branches_seen = '0;
      flushes_seen  = '0;
   endtask

   function automatic logic [btbp_pkg::HIST_W-1:0] counter_slot(
         input int e, input logic [btbp_pkg::ADDR_W-1:0] pc,
         input logic [btbp_pkg::HIST_W-1:0] mask);
      logic [btbp_pkg::HIST_W-1:0] hist;
      logic [btbp_pkg::HIST_W-1:0] slot;
      hist = model_cfg.hist_shared ? shared_hist : entry_hist[e];
      case (model_cfg.share_mode)
         btbp_pkg::SHARE_HISTORY: slot = hist;
         btbp_pkg::SHARE_LOW_PC:  slot = hist ^ pc[btbp_pkg::LSHARE_LSB +: btbp_pkg::HIST_W];
         btbp_pkg::SHARE_HIGH_PC: slot = hist ^ pc[btbp_pkg::GSHARE_LSB +: btbp_pkg::HIST_W];
         default:                 slot = '0;
      endcase
      return slot & mask;
   endfunction

   // Work out the result of one accepted transaction and advance the state
   task automatic predict_branch(input branch_op_type op, output branch_result_type res);
      int                          e;
      int                          hlen;
      int                          tlen;
      logic [btbp_pkg::TAG_W-1:0]  tg;
      logic [btbp_pkg::HIST_W-1:0] mask;
      logic [btbp_pkg::HIST_W-1:0] slot;
      logic [btbp_pkg::HIST_W-1:0] hist;
      logic [btbp_pkg::CNT_W-1:0]  cnt;
      logic [btbp_pkg::ADDR_W-1:0] fall_through;
      bit                          hit;
      bit                          pred;
      bit                          mis;
      hlen = model_cfg.history_bits;
      if (hlen < 1) hlen = 1;
      if (hlen > btbp_pkg::MAX_HISTORY) hlen = btbp_pkg::MAX_HISTORY;
      mask = btbp_pkg::HIST_W'((1 << hlen) - 1);
      tlen = (model_cfg.tag_bits > btbp_pkg::TAG_W) ? btbp_pkg::TAG_W : model_cfg.tag_bits;
      tg   = btbp_pkg::TAG_W'(op.pc >> 2) & btbp_pkg::TAG_W'((64'd1 << tlen) - 1);
      e    = op.pc[2 +: btbp_pkg::IDX_W];
      fall_through = op.pc + btbp_pkg::ADDR_W'(btbp_pkg::PC_STEP);
      hit  = entry_valid[e] && (entry_tag[e] == tg);
      slot = counter_slot(e, op.pc, mask);
      cnt  = model_cfg.global_table ? shared_cnt[slot] : row_cnt[e][slot];
      pred = hit && (cnt >= btbp_pkg::CNT_WEAK_T);
      res.predict_taken    = pred;
      res.predicted_target = pred ? entry_target[e] : fall_through;
      mis = 1'b0;
      if (op.opcode == btbp_pkg::OP_UPDATE) begin
         if (!hit) begin
            entry_tag[e] = tg;
            if (!model_cfg.hist_shared) entry_hist[e] = '0;
            if (!model_cfg.global_table)
               for (int i = 0; i <= int'(mask); i++) row_cnt[e][i] = btbp_pkg::CNT_WEAK_NT;
            entry_valid[e] = 1'b1;
         end
         entry_target[e] = op.actual_target;
         slot = counter_slot(e, op.pc, mask);
         cnt  = model_cfg.global_table ? shared_cnt[slot] : row_cnt[e][slot];
         if (op.actual_taken) begin
            if (cnt != btbp_pkg::CNT_STRONG_T) cnt = cnt + 1'b1;
         end else begin
            if (cnt != btbp_pkg::CNT_STRONG_NT) cnt = cnt - 1'b1;
         end
         if (model_cfg.global_table) shared_cnt[slot] = cnt;
         else row_cnt[e][slot] = cnt;
         hist = model_cfg.hist_shared ? shared_hist : entry_hist[e];
         hist = ((hist << 1) & mask) | btbp_pkg::HIST_W'(op.actual_taken);
         if (model_cfg.hist_shared) shared_hist = hist;
         else entry_hist[e] = hist;
         branches_seen++;
         if (pred != op.actual_taken) mis = 1'b1;
         else if (op.actual_taken) mis = (op.actual_target != op.earlier_prediction);
         else mis = (fall_through != op.earlier_prediction);
         if (mis) flushes_seen++;
      end
      res.mispredicted = mis;
      res.branch_count = branches_seen;
      res.flush_count  = flushes_seen;
   endtask

   task automatic send_item(input branch_op_type op, output branch_result_type res);
      while (!steady && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.opcode             <= op.opcode;
      req_bus.pc                 <= op.pc;
      req_bus.actual_target      <= op.actual_target;
      req_bus.actual_taken       <= op.actual_taken;
      req_bus.earlier_prediction <= op.earlier_prediction;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_branch(op, res);
      pending_results.push_back(res);
   endtask

   task automatic send_fields(input logic opcode, input logic [btbp_pkg::ADDR_W-1:0] pc,
                              input logic [btbp_pkg::ADDR_W-1:0] target, input logic taken,
                              input logic [btbp_pkg::ADDR_W-1:0] earlier);
      branch_op_type     op;
      branch_result_type res;
      op = '{opcode: opcode, pc: pc, actual_target: target, actual_taken: taken,
             earlier_prediction: earlier};
      send_item(op, res);
   endtask

   // Hold the sender until every transaction has come back and the pipeline is empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [btbp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [btbp_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic gh, input logic gt, input logic [1:0] sm,
                            input logic [3:0] hb, input logic [4:0] tb);
      write_reg(btbp_pkg::CSR_GLOBAL_HISTORY, btbp_pkg::CSR_W'(gh));
      write_reg(btbp_pkg::CSR_GLOBAL_TABLE, btbp_pkg::CSR_W'(gt));
      write_reg(btbp_pkg::CSR_SHARE_MODE, btbp_pkg::CSR_W'(sm));
      write_reg(btbp_pkg::CSR_HISTORY_BITS, btbp_pkg::CSR_W'(hb));
      write_reg(btbp_pkg::CSR_TAG_BITS, tb);
      csr_we <= 1'b0;
      model_cfg = '{hist_shared: gh, global_table: gt, share_mode: sm,
                    history_bits: hb, tag_bits: tb};
      @(posedge clock);
   endtask

   // Lookups and updates on an empty table, pc extremes and a fall-through that wraps
   task automatic test_cold_lookups();
      send_fields(btbp_pkg::OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
      send_fields(btbp_pkg::OP_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_fields(btbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
      send_fields(btbp_pkg::OP_UPDATE, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 32'h0000_0000);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0000_0004);
      drain();
   endtask

   // Allocate, train to taken, hit, then evict with an aliasing pc
   task automatic test_allocation();
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b1, 32'h0000_1044);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b1, 32'h0000_2000);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b1, 32'h0000_2000);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b1, 32'h0000_2000);
      send_fields(btbp_pkg::OP_PREDICT, 32'h0000_1040, 32'h0, 1'b0, 32'h0);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_1040, 32'h0000_3000, 1'b1, 32'h0000_2000);
      send_fields(btbp_pkg::OP_UPDATE, 32'h8000_1040, 32'hDEAD_BEEC, 1'b0, 32'h8000_1044);
      send_fields(btbp_pkg::OP_PREDICT, 32'h0000_1040, 32'h0, 1'b0, 32'h0);
      drain();
   endtask

   // Clamped lengths, the unused share mode and the two tag extremes
   task automatic test_mode_corners();
      configure(1'b1, 1'b1, btbp_pkg::SHARE_HIGH_PC, 4'd0, 5'd31);
      send_fields(btbp_pkg::OP_UPDATE, 32'h00FF_0010, 32'h1234_5678, 1'b1, 32'h00FF_0014);
      send_fields(btbp_pkg::OP_UPDATE, 32'h00FF_0010, 32'h1234_5678, 1'b1, 32'h1234_5678);
      send_fields(btbp_pkg::OP_PREDICT, 32'h00FF_0010, 32'h0, 1'b0, 32'h0);
      drain();
      configure(1'b0, 1'b1, 2'd3, 4'd15, 5'd0);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_0020, 32'hAAAA_AAA8, 1'b1, 32'hAAAA_AAA8);
      send_fields(btbp_pkg::OP_UPDATE, 32'h7FFF_FFA0, 32'h5555_5554, 1'b1, 32'h5555_5554);
      send_fields(btbp_pkg::OP_PREDICT, 32'h1234_5620, 32'h0, 1'b0, 32'h0);
      drain();
      configure(1'b1, 1'b0, btbp_pkg::SHARE_LOW_PC, 4'd1, 5'd30);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_0ABC, 32'h0000_0100, 1'b0, 32'h0000_0AC0);
      send_fields(btbp_pkg::OP_UPDATE, 32'h0000_0ABC, 32'h0000_0100, 1'b1, 32'h0000_0100);
      send_fields(btbp_pkg::OP_PREDICT, 32'h0000_0ABC, 32'h0, 1'b0, 32'h0);
      drain();
   endtask

   task automatic refill_hot_set();
      for (int i = 0; i < 16; i++) begin
         hot_pc[i] = $urandom();
         // odd slots may alias the previous branch: same entry, other tag
         if (i % 2 == 1 && $urandom_range(1)) begin
            hot_pc[i] = $urandom();
            hot_pc[i][2 +: btbp_pkg::IDX_W] = hot_pc[i-1][2 +: btbp_pkg::IDX_W];
         end
         hot_target[i] = $urandom();
         hot_bias[i]   = $urandom_range(4);
         hot_step[i]   = 0;
      end
   endtask

   task automatic run_phase(input int count);
      branch_op_type     op;
      branch_result_type res;
      int                sent;
      int                k;
      int                pick;
      bit                taken;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         k    = $urandom_range(15);
         if (pick < 70) begin
            // lookup followed by its resolution
            op = '{opcode: btbp_pkg::OP_PREDICT, pc: hot_pc[k], actual_target: $urandom(),
                   actual_taken: 1'($urandom_range(1)), earlier_prediction: $urandom()};
            send_item(op, res);
            case (hot_bias[k])
               0:       taken = 1'b1;
               1:       taken = 1'b0;
               2:       taken = hot_step[k][0];
               3:       taken = (hot_step[k] % 3) != 0;
               default: taken = 1'($urandom_range(1));
            endcase
            if ($urandom_range(19) == 0) taken = ~taken;
            hot_step[k]++;
            op.opcode        = btbp_pkg::OP_UPDATE;
            op.actual_taken  = taken;
            op.actual_target = ($urandom_range(9) == 0) ? $urandom() : hot_target[k];
            case ($urandom_range(9))
               0:       op.earlier_prediction = $urandom();
               1:       op.earlier_prediction = taken ? op.actual_target : hot_pc[k] + 32'd4;
               default: op.earlier_prediction = res.predicted_target;
            endcase
            send_item(op, res);
            sent += 2;
         end else begin
            op = '{opcode: (pick < 85) ? btbp_pkg::OP_UPDATE : btbp_pkg::OP_PREDICT,
                   pc: $urandom_range(1) ? hot_pc[k] : $urandom(),
                   actual_target: $urandom(), actual_taken: 1'($urandom_range(1)),
                   earlier_prediction: $urandom()};
            send_item(op, res);
            sent++;
         end
      end
      drain();
   endtask

   task automatic test_random_traffic();
      refill_hot_set();
      configure(1'b0, 1'b0, btbp_pkg::SHARE_HISTORY, btbp_pkg::HISTORY_BITS_RESET,
                btbp_pkg::TAG_BITS_RESET);
      run_phase(180);
      configure(1'b1, 1'b1, btbp_pkg::SHARE_HIGH_PC, 4'd8, 5'd0);
      steady = 1;
      run_phase(180);
      steady = 0;
      configure(1'b0, 1'b0, btbp_pkg::SHARE_LOW_PC, 4'd1, 5'd30);
      run_phase(180);
      refill_hot_set();
      for (int p = 0; p < 3; p++) begin
         configure(1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                   4'($urandom_range(15)), 5'($urandom_range(31)));
         run_phase(180);
      end
   endtask

   initial begin
      reset                      <= 1'b1;
      csr_we                     <= 1'b0;
      csr_index                  <= btbp_pkg::CSR_GLOBAL_HISTORY;
      csr_wdata                  <= '0;
      req_bus.valid              <= 1'b0;
      req_bus.opcode             <= btbp_pkg::OP_PREDICT;
      req_bus.pc                 <= '0;
      req_bus.actual_target      <= '0;
      req_bus.actual_taken       <= 1'b0;
      req_bus.earlier_prediction <= '0;
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_cold_lookups();
      test_allocation();
      test_mode_corners();
      test_random_traffic();
      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
